[hw/rtl/eps_pkg.sv]
// package: types and codes for the event priority scheduler
`default_nettype none
package eps_pkg;

    localparam int CAPACITY_DEF = 16;

    typedef enum logic [1:0] {
        CMD_SCHEDULE  = 2'd0,
        CMD_CANCEL    = 2'd1,
        CMD_RUN_NEXT  = 2'd2,
        CMD_RUN_UNTIL = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_SCHEDULED = 3'd0,
        KIND_REJECTED  = 3'd1,
        KIND_CANCEL    = 3'd2,
        KIND_EXECUTED  = 3'd3,
        KIND_DISCARDED = 3'd4,
        KIND_DONE      = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] event_time;
        logic [15:0] node;
        logic [31:0] target_id;
        logic [31:0] until_time;
    } in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] out_id;
        logic [31:0] out_time;
        logic [15:0] out_node;
        logic [31:0] now_time;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [31:0] ev_time;
        logic [15:0] node;
        logic [31:0] id;
    } entry_t;

endpackage
`default_nettype wire

[hw/rtl/event_priority_scheduler.sv]
// top level: event priority scheduler with slot memory and scanning search
// One command is taken at a time. Schedule walks the valid bits from slot 0 up
// to the first free slot. Cancel, run next and each pop of run until scan
// every slot of the entry memory, one read per cycle through a registered read
// port; run until repeats the scan for every popped entry and then sends the
// closing beat. A new command is accepted once the last beat of the previous
// one is registered.
`default_nettype none
module event_priority_scheduler #(
    parameter int CAPACITY = eps_pkg::CAPACITY_DEF
) (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           s_valid,
    output logic          s_ready,
    input  eps_pkg::in_t  s_data,
    output logic          m_valid,
    input  wire           m_ready,
    output eps_pkg::out_t m_data
);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = IW + 1;

    eps_pkg::state_t state_reg, state_next;
    eps_pkg::in_t    in_reg, in_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pend_reg, pend_next;
    logic [IW-1:0]   pidx_reg, pidx_next;
    logic            found_reg, found_next;
    logic [IW-1:0]   bidx_reg, bidx_next;
    eps_pkg::entry_t best_reg, best_next;
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [CAPACITY-1:0] canc_reg, canc_next;
    logic [31:0]     next_id_reg, next_id_next;
    logic [31:0]     now_reg, now_next;
    logic            out_valid_reg, out_valid_next;
    eps_pkg::out_t   out_reg, out_next;

    eps_pkg::entry_t mem [CAPACITY];
    eps_pkg::entry_t rdata_reg;
    logic            we;
    logic [IW-1:0]   waddr;
    eps_pkg::entry_t wdata;
    logic            out_free, load;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[cnt_reg[IW-1:0]];
    end

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == eps_pkg::ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        state_next   = state_reg;
        in_next      = in_reg;
        cnt_next     = cnt_reg;
        pend_next    = 1'b0;
        pidx_next    = pidx_reg;
        found_next   = found_reg;
        bidx_next    = bidx_reg;
        best_next    = best_reg;
        valid_next   = valid_reg;
        canc_next    = canc_reg;
        next_id_next = next_id_reg;
        now_next     = now_reg;
        out_next     = out_reg;
        load         = 1'b0;
        we           = 1'b0;
        waddr        = cnt_reg[IW-1:0];
        wdata        = '{ev_time: in_reg.event_time, node: in_reg.node, id: next_id_reg};
        unique case (state_reg)
            eps_pkg::ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    state_next = (s_data.cmd == eps_pkg::CMD_SCHEDULE) ?
                                 eps_pkg::ST_SCHED : eps_pkg::ST_SCAN;
                end
            end
            eps_pkg::ST_SCHED: begin
                if (!valid_reg[cnt_reg[IW-1:0]]) begin
                    if (out_free) begin
                        we = 1'b1;
                        valid_next[cnt_reg[IW-1:0]] = 1'b1;
                        canc_next[cnt_reg[IW-1:0]]  = 1'b0;
                        next_id_next = next_id_reg + 32'd1;
                        load = 1'b1;
                        out_next = '{kind: eps_pkg::KIND_SCHEDULED, out_id: next_id_reg,
                                     out_time: in_reg.event_time, out_node: in_reg.node,
                                     now_time: now_reg, last: 1'b1};
                        state_next = eps_pkg::ST_IDLE;
                    end
                end else if (cnt_reg[IW-1:0] == IW'(CAPACITY - 1)) begin
                    if (out_free) begin
                        load = 1'b1;
                        out_next = '{kind: eps_pkg::KIND_REJECTED, out_id: '0,
                                     out_time: '0, out_node: '0,
                                     now_time: now_reg, last: 1'b1};
                        state_next = eps_pkg::ST_IDLE;
                    end
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            eps_pkg::ST_SCAN: begin
                if (cnt_reg != CW'(CAPACITY)) begin
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[IW-1:0];
                    cnt_next  = cnt_reg + CW'(1);
                end else if (!pend_reg) begin
                    state_next = eps_pkg::ST_DECIDE;
                end
                if (pend_reg && valid_reg[pidx_reg]) begin
                    if (in_reg.cmd == eps_pkg::CMD_CANCEL) begin
                        if (rdata_reg.id == in_reg.target_id) begin
                            canc_next[pidx_reg] = 1'b1;
                        end
                    end else if (!found_reg || (rdata_reg < best_reg)) begin
                        found_next = 1'b1;
                        bidx_next  = pidx_reg;
                        best_next  = rdata_reg;
                    end
                end
            end
            eps_pkg::ST_DECIDE: begin
                if (out_free) begin
                    load = 1'b1;
                    state_next = eps_pkg::ST_IDLE;
                    if (in_reg.cmd == eps_pkg::CMD_CANCEL) begin
                        out_next = '{kind: eps_pkg::KIND_CANCEL, out_id: in_reg.target_id,
                                     out_time: '0, out_node: '0,
                                     now_time: now_reg, last: 1'b1};
                    end else if (!found_reg || (in_reg.cmd == eps_pkg::CMD_RUN_UNTIL &&
                                 best_reg.ev_time > in_reg.until_time)) begin
                        out_next = '{kind: eps_pkg::KIND_DONE, out_id: '0,
                                     out_time: '0, out_node: '0,
                                     now_time: now_reg, last: 1'b1};
                    end else begin
                        valid_next[bidx_reg] = 1'b0;
                        canc_next[bidx_reg]  = 1'b0;
                        if (!canc_reg[bidx_reg]) begin
                            now_next = best_reg.ev_time;
                        end
                        out_next = '{kind: canc_reg[bidx_reg] ? eps_pkg::KIND_DISCARDED :
                                           eps_pkg::KIND_EXECUTED,
                                     out_id: best_reg.id, out_time: best_reg.ev_time,
                                     out_node: best_reg.node,
                                     now_time: canc_reg[bidx_reg] ? now_reg : best_reg.ev_time,
                                     last: (in_reg.cmd == eps_pkg::CMD_RUN_NEXT)};
                        if (in_reg.cmd == eps_pkg::CMD_RUN_UNTIL) begin
                            state_next = eps_pkg::ST_SCAN;
                            cnt_next   = '0;
                            found_next = 1'b0;
                        end
                    end
                end
            end
            default: state_next = eps_pkg::ST_IDLE;
        endcase
        out_valid_next = load ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= eps_pkg::ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            valid_reg     <= '0;
            canc_reg      <= '0;
            next_id_reg   <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            valid_reg     <= valid_next;
            canc_reg      <= canc_next;
            next_id_reg   <= next_id_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
        end
        in_reg   <= in_next;
        pidx_reg <= pidx_next;
        bidx_reg <= bidx_next;
        best_reg <= best_next;
        out_reg  <= out_next;
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted a second command while busy");

    a_id_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && out_next.kind == eps_pkg::KIND_SCHEDULED) |=>
        (next_id_reg == $past(next_id_reg) + 32'd1))
        else $error("id counter did not advance on schedule");

    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && out_next.kind == eps_pkg::KIND_REJECTED) |-> (&valid_reg))
        else $error("schedule rejected with a free slot");

    a_exec_now: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.kind == eps_pkg::KIND_EXECUTED) |->
        (out_reg.now_time == out_reg.out_time))
        else $error("executed beat with wrong current time");

endmodule
`default_nettype wire

[bench/tb_top.sv]
// testbench for the event priority scheduler: driver, queue predictor and scoreboard
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import eps_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int STALL_LIMIT = 20000;

    class event_scoreboard;
        bit          q_valid [CAP];
        bit          q_cancel [CAP];
        logic [31:0] q_time [CAP];
        logic [15:0] q_node [CAP];
        logic [31:0] q_id [CAP];
        logic [31:0] id_count;
        logic [31:0] sim_now;
        out_t        pending [$];
        int          errors;

        function new();
            for (int i = 0; i < CAP; i++) begin
                q_valid[i] = 0;
                q_cancel[i] = 0;
            end
            id_count = 0;
            sim_now = 0;
            errors = 0;
        endfunction

        function int occupancy();
            int n;
            n = 0;
            for (int i = 0; i < CAP; i++) n += q_valid[i];
            return n;
        endfunction

        function void push(kind_t k, logic [31:0] id, logic [31:0] t, logic [15:0] nd,
                           bit lst);
            out_t r;
            r.kind = k;
            r.out_id = id;
            r.out_time = t;
            r.out_node = nd;
            r.now_time = sim_now;
            r.last = lst;
            pending = {pending, r};
        endfunction

        function int head_slot();
            int b;
            b = -1;
            for (int i = 0; i < CAP; i++) begin
                if (!q_valid[i]) continue;
                if (b < 0) b = i;
                else if (q_time[i] != q_time[b]) begin
                    if (q_time[i] < q_time[b]) b = i;
                end else if (q_node[i] != q_node[b]) begin
                    if (q_node[i] < q_node[b]) b = i;
                end else if (q_id[i] < q_id[b]) b = i;
            end
            return b;
        endfunction

        function void pop_slot(int h, bit lst);
            kind_t k;
            q_valid[h] = 0;
            if (q_cancel[h]) k = KIND_DISCARDED;
            else begin
                sim_now = q_time[h];
                k = KIND_EXECUTED;
            end
            q_cancel[h] = 0;
            push(k, q_id[h], q_time[h], q_node[h], lst);
        endfunction

        function void note_input(in_t d);
            int f;
            int h;
            case (cmd_t'(d.cmd))
                CMD_SCHEDULE: begin
                    f = -1;
                    for (int i = CAP - 1; i >= 0; i--) if (!q_valid[i]) f = i;
                    if (f < 0) push(KIND_REJECTED, 0, 0, 0, 1);
                    else begin
                        q_valid[f] = 1;
                        q_cancel[f] = 0;
                        q_time[f] = d.event_time;
                        q_node[f] = d.node;
                        q_id[f] = id_count;
                        push(KIND_SCHEDULED, id_count, d.event_time, d.node, 1);
                        id_count++;
                    end
                end
                CMD_CANCEL: begin
                    for (int i = 0; i < CAP; i++)
                        if (q_valid[i] && q_id[i] == d.target_id) q_cancel[i] = 1;
                    push(KIND_CANCEL, d.target_id, 0, 0, 1);
                end
                CMD_RUN_NEXT: begin
                    h = head_slot();
                    if (h < 0) push(KIND_DONE, 0, 0, 0, 1);
                    else pop_slot(h, 1);
                end
                default: begin
                    h = head_slot();
                    while (h >= 0 && q_time[h] <= d.until_time) begin
                        pop_slot(h, 0);
                        h = head_slot();
                    end
                    push(KIND_DONE, 0, 0, 0, 1);
                end
            endcase
        endfunction

        function void check_result(out_t a);
            out_t e;
            if (pending.size() == 0) begin
                $error("unexpected result beat kind=%0d", a.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.kind !== e.kind) begin
                $error("kind exp %0d got %0d", e.kind, a.kind); errors++;
            end
            if (a.out_id !== e.out_id) begin
                $error("out_id exp %0h got %0h", e.out_id, a.out_id); errors++;
            end
            if (a.out_time !== e.out_time) begin
                $error("out_time exp %0h got %0h", e.out_time, a.out_time); errors++;
            end
            if (a.out_node !== e.out_node) begin
                $error("out_node exp %0h got %0h", e.out_node, a.out_node); errors++;
            end
            if (a.now_time !== e.now_time) begin
                $error("now_time exp %0h got %0h", e.now_time, a.now_time); errors++;
            end
            if (a.last !== e.last) begin
                $error("last exp %0b got %0b", e.last, a.last); errors++;
            end
        endfunction
    endclass

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    in_t   s_data;
    logic  m_valid;
    logic  m_ready;
    out_t  m_data;

    event_scoreboard sb;
    int idle_cycles;
    logic [31:0] recent_ids [$];
    logic [31:0] time_base;

    event_priority_scheduler #(.CAPACITY(CAP)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // scoreboard and watchdog on the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver stall pattern
    initial begin
        int mode;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60)) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    task automatic send_beat(logic [1:0] c, logic [31:0] t, logic [15:0] nd,
                             logic [31:0] tid, logic [31:0] et);
        in_t d;
        d.cmd = c;
        d.event_time = t;
        d.node = nd;
        d.target_id = tid;
        d.until_time = et;
        s_data <= d;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (c == CMD_SCHEDULE) begin
            recent_ids = {recent_ids, sb.id_count - 32'd1};
            if (recent_ids.size() > 24) void'(recent_ids.pop_front());
        end
    endtask

    task automatic pause_sender();
        s_valid <= 0;
        s_data <= in_t'({$urandom, $urandom, $urandom, $urandom});
        repeat ($urandom_range(1, 12)) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_target();
        if (recent_ids.size() > 0 && $urandom_range(0, 4) != 0)
            return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        return $urandom;
    endfunction

    task automatic random_item(int bias);
        int r;
        logic [31:0] t;
        r = $urandom_range(0, 99);
        t = ($urandom_range(0, 7) == 0) ? $urandom : time_base + $urandom_range(0, 300);
        if (r < bias)
            send_beat(CMD_SCHEDULE, t,
                      16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3)),
                      $urandom, $urandom);
        else if (r < bias + 15)
            send_beat(CMD_CANCEL, $urandom, 16'($urandom), pick_target(), $urandom);
        else if (r < bias + 30)
            send_beat(CMD_RUN_NEXT, $urandom, 16'($urandom), $urandom, $urandom);
        else begin
            send_beat(CMD_RUN_UNTIL, $urandom, 16'($urandom), $urandom,
                      ($urandom_range(0, 9) == 0) ? $urandom : time_base + $urandom_range(0, 200));
            time_base += $urandom_range(0, 150);
        end
    endtask

    initial begin
        int sent;
        int burst;
        sb = new();
        idle_cycles = 0;
        time_base = 0;
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: empty queue, extremes, ties, cancel, full queue, drain
        send_beat(CMD_RUN_NEXT, 0, 0, 0, 0);
        send_beat(CMD_RUN_UNTIL, 0, 0, 0, 32'hffff_ffff);
        send_beat(CMD_SCHEDULE, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 0);
        send_beat(CMD_SCHEDULE, 0, 0, 0, 0);
        send_beat(CMD_SCHEDULE, 5, 7, 0, 0);
        send_beat(CMD_SCHEDULE, 5, 7, 0, 0);
        send_beat(CMD_SCHEDULE, 5, 3, 0, 0);
        send_beat(CMD_CANCEL, 0, 0, 3, 0);
        send_beat(CMD_CANCEL, 0, 0, 32'hffff_ffff, 0);
        send_beat(CMD_RUN_NEXT, 0, 0, 0, 0);
        send_beat(CMD_RUN_UNTIL, 0, 0, 0, 5);
        for (int i = 0; i < CAP + 1; i++)
            send_beat(CMD_SCHEDULE, $urandom_range(0, 40), 16'($urandom_range(0, 2)), 0, 0);
        send_beat(CMD_CANCEL, 0, 0, 10, 0);
        send_beat(CMD_RUN_UNTIL, 0, 0, 0, 32'hffff_ffff);
        time_base = sb.sim_now;

        // random: alternate fill-heavy and drain-heavy phases
        sent = 0;
        while (sent < 380) begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst; i++) begin
                random_item(((sent / 40) % 2 == 0) ? 60 : 25);
                sent++;
            end
            if ($urandom_range(0, 2) != 0) pause_sender();
        end
        send_beat(CMD_RUN_UNTIL, 0, 0, 0, 32'hffff_ffff);
        s_valid <= 0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
